// File: rtl/cqfid_pkg.sv
// Shared types and constants for the circular queue with front insert and delete.
// Holds the request and status codes, the result record and the stream widths.
// No dependencies.
`default_nettype none

package cqfid_pkg;

    // Request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_APPEND     = 2'd0,
        REQ_POP        = 2'd1,
        REQ_PUSH_FRONT = 2'd2,
        REQ_DELETE     = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Field widths fixed by the stream format
    localparam int VALUE_BITS    = 32;
    localparam int POS_BITS      = 6;
    localparam int LEN_BITS      = 7;
    localparam int REQ_BITS      = 2;
    localparam int S_TDATA_BITS  = 40;
    localparam int M_TDATA_BITS  = 48;

    // One result record
    typedef struct packed {
        logic [VALUE_BITS-1:0] removed_value;
        logic                  removed_valid;
        status_t               status;
        logic [LEN_BITS-1:0]   length;
        logic                  is_empty;
        logic                  is_full;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/cqfid_mem.sv
// Slot storage for the queue: one write port, one read port, registered read data.
// Contents are not reset. Depends on nothing.
`default_nettype none

module cqfid_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/cqfid_ctrl.sv
// Request sequencer for the queue: head and count registers, slot memory access,
// the gap-closing shift of a positional delete, and the output register.
// Depends on cqfid_pkg.
`default_nettype none

module cqfid_ctrl
    import cqfid_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ENTRY_BITS = 32,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request side
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire logic [REQ_BITS-1:0]   req_type,
    input  wire logic [VALUE_BITS-1:0] item_value,
    input  wire logic [POS_BITS-1:0]   position,
    // result side
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output result_t                    res,
    // slot memory
    output logic                       mem_wr_en,
    output logic [AW-1:0]              mem_wr_addr,
    output logic [ENTRY_BITS-1:0]      mem_wr_data,
    output logic                       mem_rd_en,
    output logic [AW-1:0]              mem_rd_addr,
    input  wire logic [ENTRY_BITS-1:0] mem_rd_data
);

    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_CAP,
        S_DEL_CAP,
        S_DEL_SHIFT,
        S_RESULT
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   left_reg, left_next;
    result_t         pend_reg, pend_next;
    result_t         out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic [AW:0]     tail_sum;
    logic [AW-1:0]   tail_addr;
    logic [AW:0]     del_sum;
    logic [AW-1:0]   del_addr;
    logic [AW-1:0]   head_inc;
    logic [AW-1:0]   head_dec;
    logic [AW-1:0]   cur_inc;
    logic [AW-1:0]   cur_inc2;
    logic [VALUE_BITS-1:0] rd_value;
    logic            is_empty_now;
    logic            is_full_now;
    logic            pos_bad;
    req_t            req;

    // Build a result record from the new length
    function automatic result_t make_result(input logic [VALUE_BITS-1:0] value,
                                            input logic                  valid,
                                            input status_t               st,
                                            input logic [CW-1:0]         cnt);
        result_t r;
        r.removed_value = value;
        r.removed_valid = valid;
        r.status        = st;
        r.length        = LEN_BITS'(cnt);
        r.is_empty      = (cnt == '0);
        r.is_full       = (cnt == DEPTH_C);
        return r;
    endfunction

    // Address arithmetic: ring offsets stay below twice the depth
    always_comb
    begin
        tail_sum  = {1'b0, head_reg} + (AW + 1)'(count_reg);
        tail_addr = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
        del_sum   = {1'b0, head_reg} + (AW + 1)'(position);
        del_addr  = (del_sum >= DEPTH_W) ? AW'(del_sum - DEPTH_W) : AW'(del_sum);
        head_inc  = (head_reg == LAST_IX) ? '0 : head_reg + 1'b1;
        head_dec  = (head_reg == '0) ? LAST_IX : head_reg - 1'b1;
        cur_inc   = (cur_reg == LAST_IX) ? '0 : cur_reg + 1'b1;
        cur_inc2  = (cur_inc == LAST_IX) ? '0 : cur_inc + 1'b1;
    end

    assign rd_value     = VALUE_BITS'(mem_rd_data);
    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == DEPTH_C);
    assign pos_bad      = (32'(position) >= 32'(count_reg));
    assign req          = req_t'(req_type);

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cur_reg;
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = cur_inc;

        // output register drains independently
        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req) inside
                        REQ_APPEND, REQ_PUSH_FRONT:
                        begin
                            state_next = S_RESULT;
                            if (is_full_now)
                            begin
                                pend_next = make_result('0, 1'b0, ST_FULL, count_reg);
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = ENTRY_BITS'(item_value);
                                if (is_empty_now)
                                begin
                                    head_next   = '0;
                                    mem_wr_addr = '0;
                                end
                                else if (req == REQ_APPEND)
                                begin
                                    mem_wr_addr = tail_addr;
                                end
                                else
                                begin
                                    head_next   = head_dec;
                                    mem_wr_addr = head_dec;
                                end
                                count_next = count_reg + 1'b1;
                                pend_next  = make_result('0, 1'b0, ST_OK, count_reg + 1'b1);
                            end
                        end
                        REQ_POP:
                        begin
                            if (is_empty_now)
                            begin
                                state_next = S_RESULT;
                                pend_next  = make_result('0, 1'b0, ST_EMPTY, count_reg);
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = head_reg;
                                state_next  = S_POP_CAP;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (is_empty_now)
                            begin
                                state_next = S_RESULT;
                                pend_next  = make_result('0, 1'b0, ST_EMPTY, count_reg);
                            end
                            else if (pos_bad)
                            begin
                                state_next = S_RESULT;
                                pend_next  = make_result('0, 1'b0, ST_RANGE, count_reg);
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = del_addr;
                                cur_next    = del_addr;
                                left_next   = count_reg - 1'b1 - CW'(position);
                                state_next  = S_DEL_CAP;
                            end
                        end
                    endcase
                end
            end

            // head entry is on the read port
            S_POP_CAP:
            begin
                count_next = count_reg - 1'b1;
                head_next  = (count_reg == CW'(1)) ? '0 : head_inc;
                pend_next  = make_result(rd_value, 1'b1, ST_OK, count_reg - 1'b1);
                state_next = S_RESULT;
            end

            // deleted entry is on the read port; start the shift if any
            S_DEL_CAP:
            begin
                pend_next.removed_value = rd_value;
                if (left_reg == '0)
                begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        head_next = '0;
                    end
                    pend_next  = make_result(rd_value, 1'b1, ST_OK, count_reg - 1'b1);
                    state_next = S_RESULT;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cur_inc;
                    state_next  = S_DEL_SHIFT;
                end
            end

            // move one entry forward per cycle, reading one ahead
            S_DEL_SHIFT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cur_reg;
                mem_wr_data = mem_rd_data;
                cur_next    = cur_inc;
                left_next   = left_reg - 1'b1;
                if (left_reg == CW'(1))
                begin
                    count_next = count_reg - 1'b1;
                    pend_next  = make_result(pend_reg.removed_value, 1'b1, ST_OK,
                                             count_reg - 1'b1);
                    state_next = S_RESULT;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cur_inc2;
                end
            end

            // hand the result to the output register once it is free
            S_RESULT:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            left_reg      <= '0;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Checks
    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    ap_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0))
        else $error("empty queue with nonzero head");

    ap_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("read and write to the same slot in one cycle");

    ap_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.removed_valid) |-> (out_reg.status == ST_OK))
        else $error("removed entry reported on a refused request");

    ap_shift_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL_SHIFT) |-> (left_reg != '0))
        else $error("shift step with nothing left to move");

endmodule

`default_nettype wire

// File: rtl/circular_queue_with_front_insert_delete.sv
// Circular queue with append, remove head, front insert and positional delete.
// Flow: append, front insert and refusals go through S_RESULT to the output register; remove head
// first captures the head slot in S_POP_CAP; a positional delete captures the entry in S_DEL_CAP,
// then closes the gap in S_DEL_SHIFT, one slot moved per cycle. A request is taken only in S_IDLE,
// so one request is in flight at a time, and a held result stalls the input. Reset clears head,
// count and handshake state; slot memory is not cleared. Depends on cqfid_pkg, cqfid_ctrl, cqfid_mem.
`default_nettype none

module circular_queue_with_front_insert_delete
    import cqfid_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ENTRY_BITS = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // request stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,  // item_value[31:0], position[37:32], zero pad
    input  wire logic [REQ_BITS-1:0]     s_tuser,  // req_type[1:0]
    // result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_TDATA_BITS-1:0]      m_tdata,  // removed_value[31:0], status[33:32],
                                                   // length[40:34], is_empty[41], is_full[42],
                                                   // zero pad
    output logic [0:0]                   m_tuser   // removed_valid[0]
);

    localparam int AW = $clog2(DEPTH);

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [ENTRY_BITS-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [ENTRY_BITS-1:0] mem_rd_data;
    result_t               res;

    cqfid_ctrl #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_type    (s_tuser),
        .item_value  (s_tdata[VALUE_BITS-1:0]),
        .position    (s_tdata[VALUE_BITS +: POS_BITS]),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    cqfid_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Pack the result stream
    assign m_tdata = {5'b0, res.is_full, res.is_empty, res.length, res.status,
                      res.removed_value};
    assign m_tuser = res.removed_valid;

endmodule

`default_nettype wire
